/* src/actt_pkg.sv */
// ----------------------------------------------------------------------------
// actt_pkg: shared constants for the arc to chord tessellator
// Angle constants, chord limits, CORDIC settings and table.
// ----------------------------------------------------------------------------
package actt_pkg;

   localparam int STEP_DEGREES_DEF = 18;
   localparam int MAX_CHORDS       = 20;
   localparam int FULL_TURN        = 46080;
   localparam int QUARTER_TURN     = 11520;
   localparam int HALF_TURN        = 23040;
   localparam int THREE_QUARTER    = 34560;
   localparam int CORDIC_ITERS     = 16;
   localparam int CORDIC_GAIN_Q15  = 19898;

   function automatic logic signed [31:0] atan_lut(input logic [3:0] idx);
      logic signed [31:0] v;
      unique case (idx)
         4'd0:  v = 32'sd2949120;
         4'd1:  v = 32'sd1740967;
         4'd2:  v = 32'sd919879;
         4'd3:  v = 32'sd466945;
         4'd4:  v = 32'sd234379;
         4'd5:  v = 32'sd117304;
         4'd6:  v = 32'sd58666;
         4'd7:  v = 32'sd29335;
         4'd8:  v = 32'sd14668;
         4'd9:  v = 32'sd7334;
         4'd10: v = 32'sd3667;
         4'd11: v = 32'sd1833;
         4'd12: v = 32'sd917;
         4'd13: v = 32'sd458;
         4'd14: v = 32'sd229;
         default: v = 32'sd115;
      endcase
      return v;
   endfunction

endpackage

/* src/arc_to_chord_tessellator.sv */
// ----------------------------------------------------------------------------
// arc_to_chord_tessellator
// Cuts one circular arc into up to MAX_CHORDS straight chords.
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata low bit up)
// req_     in   center_x, center_y, center_z, radius[31], start[16], end[16]
// rsp_     out  from_x, from_y, to_x, to_y, plane_z; tlast = last_chord
//
// One arc at a time. Setup counts the chords by compare and subtract against
// the step size, one step a cycle. Each point then takes a restoring divide
// for its angle, a 16-step CORDIC and two products by one shared 32x32
// multiplier, with a negation first when the angle is mirrored by a half
// turn; an arc has up to 21 points.
// Synchronous reset clears control only. A stalled rsp beat holds; the
// sequencer waits until it is taken before it overwrites the output.
// ----------------------------------------------------------------------------
module arc_to_chord_tessellator #(
   parameter int STEP_DEGREES = actt_pkg::STEP_DEGREES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // center_x[31:0], center_y[63:32], center_z[95:64], radius[126:96],
   // start_angle[142:127], end_angle[158:143], zero fill
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // from_x[31:0], from_y[63:32], to_x[95:64], to_y[127:96], plane_z[159:128]
   output logic [159:0] rsp_tdata,
   output logic         rsp_tlast
);

   localparam logic [16:0] STEP_UNITS = 17'(STEP_DEGREES * 128);

   typedef enum logic [3:0] {
      S_IDLE, S_NDIV, S_POINT, S_ADIV, S_CPREP, S_CORD, S_MULX, S_MULY,
      S_PLACE, S_EMIT
   } state_type;

   state_type            state_ff;
   logic signed [31:0]   cx_ff, cy_ff, cz_ff;
   logic [30:0]          r_ff;
   logic [16:0]          a0_ff, span_ff;
   logic [4:0]           n_ff, i_ff;
   logic [21:0]          rem_ff;    // divider remainder / span left to count
   logic [21:0]          quo_ff;    // divider quotient / dividend
   logic [4:0]           cnt_ff;
   logic signed [31:0]   x_ff, y_ff, z_ff;
   logic                 neg_ff;
   logic signed [63:0]   prod_ff;
   logic signed [31:0]   px_ff, py_ff, qx_ff, qy_ff;
   logic                 rv_ff, rl_ff;
   logic [159:0]         rd_ff;

   // one shared divider step
   logic [22:0] trial;
   logic [21:0] divisor;
   always_comb begin
      divisor = 22'(n_ff);
      trial = {rem_ff, quo_ff[21]} - {1'b0, divisor};
   end

   // one shared multiplier
   logic signed [31:0] mul_a;
   logic signed [63:0] mul_p;
   always_comb begin
      mul_a = (state_ff == S_MULX) ? x_ff : y_ff;
      mul_p = mul_a * $signed({1'b0, r_ff});
   end

   // CORDIC step
   logic signed [31:0] dx, dy;
   always_comb begin
      dx = y_ff >>> cnt_ff[3:0];
      dy = x_ff >>> cnt_ff[3:0];
   end

   // place: center + round(prod/2^15), saturate
   function automatic logic signed [31:0] place(input logic signed [31:0] c,
                                                input logic signed [63:0] p);
      logic signed [64:0] off, s;
      off = (65'(p) + 65'sd16384) >>> 15;
      s = off + 65'(c);
      if (s > 65'sd2147483647) return 32'sh7fffffff;
      if (s < -65'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   logic [16:0] a0_in, a1_in, ang;
   logic [15:0] sa, ea;
   always_comb begin
      sa = req_tdata[142:127];
      ea = req_tdata[158:143];
      a0_in = (sa >= 16'(actt_pkg::FULL_TURN)) ? 17'(sa) - 17'(actt_pkg::FULL_TURN)
                                               : 17'(sa);
      a1_in = (ea >= 16'(actt_pkg::FULL_TURN)) ? 17'(ea) - 17'(actt_pkg::FULL_TURN)
                                               : 17'(ea);
      if (a1_in < a0_in) a1_in = a1_in + 17'(actt_pkg::FULL_TURN);
      ang = a0_ff + quo_ff[16:0];
      if (ang >= 17'(actt_pkg::FULL_TURN)) ang = ang - 17'(actt_pkg::FULL_TURN);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         // a new beat in S_EMIT sets valid itself
         if (rv_ff && rsp_tready && !(state_ff == S_EMIT && i_ff != 5'd0))
            rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cx_ff   <= req_tdata[31:0];
                  cy_ff   <= req_tdata[63:32];
                  cz_ff   <= req_tdata[95:64];
                  r_ff    <= req_tdata[126:96];
                  a0_ff   <= a0_in;
                  span_ff <= a1_in - a0_in;
                  rem_ff  <= 22'(a1_in - a0_in);
                  n_ff    <= 5'd1;
                  i_ff    <= '0;
                  if (a1_in != a0_in) state_ff <= S_NDIV;
               end
            end
            S_NDIV: begin
               // n = span/step + 1, counted by subtraction, capped
               if (rem_ff >= 22'(STEP_UNITS) && n_ff != 5'(actt_pkg::MAX_CHORDS)) begin
                  rem_ff <= rem_ff - 22'(STEP_UNITS);
                  n_ff   <= n_ff + 5'd1;
               end else state_ff <= S_POINT;
            end
            S_ADIV: begin
               if (!trial[22]) rem_ff <= trial[21:0];
               else rem_ff <= {rem_ff[20:0], quo_ff[21]};
               quo_ff <= {quo_ff[20:0], ~trial[22]};
               if (cnt_ff == 5'd0) state_ff <= S_CPREP;
               else cnt_ff <= cnt_ff - 5'd1;
            end
            S_POINT: begin
               // dividend i*span, 22 bits; shifted through the divider
               rem_ff <= '0;
               quo_ff <= 22'(span_ff) * 22'(i_ff);
               cnt_ff <= 5'd21;
               state_ff <= S_ADIV;
            end
            S_CPREP: begin
               // quo_ff now holds the quotient; reduce angle to +-90 deg
               x_ff <= 32'(actt_pkg::CORDIC_GAIN_Q15);
               y_ff <= '0;
               cnt_ff <= '0;
               if (ang > 17'(actt_pkg::QUARTER_TURN) &&
                   ang < 17'(actt_pkg::THREE_QUARTER)) begin
                  z_ff <= (32'(ang) - 32'(actt_pkg::HALF_TURN)) <<< 9;
                  neg_ff <= 1'b1;
               end else if (ang >= 17'(actt_pkg::THREE_QUARTER)) begin
                  z_ff <= (32'(ang) - 32'(actt_pkg::FULL_TURN)) <<< 9;
                  neg_ff <= 1'b0;
               end else begin
                  z_ff <= 32'(ang) <<< 9;
                  neg_ff <= 1'b0;
               end
               state_ff <= S_CORD;
            end
            S_CORD: begin
               if (!z_ff[31]) begin
                  x_ff <= x_ff - dx; y_ff <= y_ff + dy;
                  z_ff <= z_ff - actt_pkg::atan_lut(cnt_ff[3:0]);
               end else begin
                  x_ff <= x_ff + dx; y_ff <= y_ff - dy;
                  z_ff <= z_ff + actt_pkg::atan_lut(cnt_ff[3:0]);
               end
               if (cnt_ff == 5'(actt_pkg::CORDIC_ITERS - 1)) begin
                  state_ff <= S_MULX;
               end else cnt_ff <= cnt_ff + 5'd1;
            end
            S_MULX: begin
               if (neg_ff) begin
                  x_ff <= -x_ff; y_ff <= -y_ff;
               end else begin
                  prod_ff <= mul_p;
                  state_ff <= S_MULY;
               end
               neg_ff <= 1'b0;
            end
            S_MULY: begin
               qx_ff <= place(cx_ff, prod_ff);
               prod_ff <= mul_p;
               state_ff <= S_PLACE;
            end
            S_PLACE: begin
               qy_ff <= place(cy_ff, prod_ff);
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (i_ff == 5'd0 || !rv_ff || rsp_tready) begin
                  if (i_ff != 5'd0) begin
                     rv_ff <= 1'b1;
                     rl_ff <= (i_ff == n_ff);
                     rd_ff <= {cz_ff, qy_ff, qx_ff, py_ff, px_ff};
                  end
                  px_ff <= qx_ff;
                  py_ff <= qy_ff;
                  i_ff  <= i_ff + 5'd1;
                  state_ff <= (i_ff == n_ff) ? S_IDLE : S_POINT;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // held result beat does not change until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("rsp beat changed while stalled");
   // never more chords than the limit
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE && state_ff != S_NDIV |-> n_ff <= 5'(actt_pkg::MAX_CHORDS)
                                                && n_ff != 5'd0)
      else $error("chord count out of range");
   // no new arc while busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("ready while busy");

endmodule

/* bench/arc_to_chord_tessellator_tb.sv */
// ----------------------------------------------------------------------------
// arc_to_chord_tessellator_tb: self-checking bench for the arc tessellator
// Drives arc beats, predicts every chord with a behavioral CORDIC and
// compares each rsp beat in order, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module arc_to_chord_tessellator_tb;

   typedef struct packed {
      logic [15:0]        end_angle;
      logic [15:0]        start_angle;
      logic [30:0]        radius;
      logic signed [31:0] center_z;
      logic signed [31:0] center_y;
      logic signed [31:0] center_x;
   } arc_t;

   typedef struct packed {
      logic signed [31:0] plane_z;
      logic signed [31:0] to_y;
      logic signed [31:0] to_x;
      logic signed [31:0] from_y;
      logic signed [31:0] from_x;
      logic               last_chord;
   } chord_t;

   localparam int STEP_UNITS = actt_pkg::STEP_DEGREES_DEF * 128;
   localparam int LIMIT      = 2000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic         rsp_tlast;

   arc_t   arc_queue[$];      // arcs waiting to be driven
   chord_t chord_queue[$];    // predicted chords, oldest first
   int     fail_count = 0;
   int     cycle_count = 0;
   bit     quiet = 1'b0;      // no idling in the last part of the run
   bit     hold_rsp = 1'b0;   // long receiver hold-off request
   logic   req_taken = 1'b0;  // req beat accepted at the last rising edge

   arc_to_chord_tessellator dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor shift, as the hardware's arithmetic shift
   function automatic int asr(int v, int s);
      return v >>> s;
   endfunction

   function automatic void sincos(int ang, output int c, output int s);
      int a, x, y, z, dx, dy;
      bit neg;
      a = ang;
      neg = 1'b0;
      x = actt_pkg::CORDIC_GAIN_Q15;
      y = 0;
      if (a > actt_pkg::QUARTER_TURN && a < actt_pkg::THREE_QUARTER) begin
         a -= actt_pkg::HALF_TURN;
         neg = 1'b1;
      end else if (a >= actt_pkg::THREE_QUARTER) begin
         a -= actt_pkg::FULL_TURN;
      end
      z = a * 512;
      for (int i = 0; i < actt_pkg::CORDIC_ITERS; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= actt_pkg::atan_lut(i[3:0]);
         end else begin
            x += dx; y -= dy; z += actt_pkg::atan_lut(i[3:0]);
         end
      end
      if (neg) begin
         x = -x; y = -y;
      end
      c = x;
      s = y;
   endfunction

   // center + round-half-up(trig*r/2^15), saturated
   function automatic logic signed [31:0] place_point(longint ctr, int trig, longint r);
      longint prod, sum;
      prod = longint'(trig) * r;
      sum = ctr + ((prod + 16384) >>> 15);
      if (sum > 64'sd2147483647) return 32'h7fffffff;
      if (sum < -64'sd2147483648) return 32'h80000000;
      return sum[31:0];
   endfunction

   function automatic void predict_chords(arc_t a);
      longint a0, a1, span, n, ang, r;
      int c, s;
      logic signed [31:0] px, py, qx, qy;
      chord_t ch;
      a0 = longint'(a.start_angle);
      a1 = longint'(a.end_angle);
      r = longint'(a.radius);
      px = '0;
      py = '0;
      if (a0 >= actt_pkg::FULL_TURN) a0 -= actt_pkg::FULL_TURN;
      if (a1 >= actt_pkg::FULL_TURN) a1 -= actt_pkg::FULL_TURN;
      if (a1 < a0) a1 += actt_pkg::FULL_TURN;
      span = a1 - a0;
      if (span == 0) return;
      n = span / STEP_UNITS + 1;
      if (n > actt_pkg::MAX_CHORDS) n = actt_pkg::MAX_CHORDS;
      for (longint i = 0; i <= n; i++) begin
         ang = a0 + (i * span) / n;
         if (ang >= actt_pkg::FULL_TURN) ang -= actt_pkg::FULL_TURN;
         sincos(int'(ang), c, s);
         qx = place_point(longint'(a.center_x), c, r);
         qy = place_point(longint'(a.center_y), s, r);
         if (i > 0) begin
            ch.from_x = px; ch.from_y = py; ch.to_x = qx; ch.to_y = qy;
            ch.plane_z = a.center_z;
            ch.last_chord = (i == n);
            chord_queue.push_back(ch);
         end
         px = qx;
         py = qy;
      end
   endfunction

   function automatic arc_t rand_arc(bit wide_angles);
      arc_t a;
      a.center_x = $urandom;
      a.center_y = $urandom;
      a.center_z = $urandom;
      case ($urandom_range(0, 3))
         0: a.radius = 31'($urandom);
         1: a.radius = 31'($urandom_range(0, 32'h00ffffff));
         2: a.radius = 31'(32'h7fffffff - $urandom_range(0, 255));
         default: a.radius = 31'($urandom_range(0, 1000));
      endcase
      if (!a.radius[30] && $urandom_range(0, 1)) begin
         a.center_x = $urandom_range(0, 32'h0fffffff) - 32'sh08000000;
         a.center_y = $urandom_range(0, 32'h0fffffff) - 32'sh08000000;
      end
      a.start_angle = wide_angles ? 16'($urandom)
                                  : 16'($urandom_range(0, actt_pkg::FULL_TURN - 1));
      case ($urandom_range(0, 5))
         0: a.end_angle = a.start_angle;
         1: a.end_angle = 16'((a.start_angle + $urandom_range(1, 4000))
                              % actt_pkg::FULL_TURN);
         default: a.end_angle = wide_angles ? 16'($urandom)
                                 : 16'($urandom_range(0, actt_pkg::FULL_TURN - 1));
      endcase
      return a;
   endfunction

   // Driver: new beats at the falling edge, random bursts of idle.
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (arc_queue.size() > 0) begin
               req_tdata <= {1'b0, arc_queue.pop_front()};
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(0, 4) == 0)
                  send_gap <= $urandom_range(1, 15);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // acceptance sampled at the rising edge
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready && !reset;
      cycle_count <= cycle_count + 1;
      if (req_tvalid && req_tready && !reset)
         predict_chords(arc_t'(req_tdata[158:0]));
   end

   // Receiver ready: bursts of stall, plus the long hold-off.
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: compare each rsp beat with the oldest prediction.
   always @(posedge clock) begin
      chord_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tlast};
         if (chord_queue.size() == 0) begin
            $display("%0t: unexpected chord beat %h", $time, got);
            fail_count <= fail_count + 1;
         end else begin
            want = chord_queue.pop_front();
            if (got !== want) begin
               $display("%0t: chord mismatch expected %h actual %h", $time, want, got);
               $display("   from (%0d,%0d)/(%0d,%0d) to (%0d,%0d)/(%0d,%0d)",
                        want.from_x, want.from_y, got.from_x, got.from_y,
                        want.to_x, want.to_y, got.to_x, got.to_y);
               $display("   z %0d/%0d last %0b/%0b", want.plane_z, got.plane_z,
                        want.last_chord, got.last_chord);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_drained();
      while (arc_queue.size() > 0 || req_tvalid || chord_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      arc_t a;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: angle extremes, wrap, zero span, beyond one turn, saturation
      a = '0;
      a.radius = 31'h00010000;
      a.start_angle = 0;     a.end_angle = 0;      arc_queue.push_back(a);
      a.start_angle = 0;     a.end_angle = 1;      arc_queue.push_back(a);
      a.start_angle = 0;     a.end_angle = 46079;  arc_queue.push_back(a);
      a.start_angle = 46079; a.end_angle = 0;      arc_queue.push_back(a);
      a.start_angle = 11520; a.end_angle = 34560;  arc_queue.push_back(a);
      a.start_angle = 34560; a.end_angle = 11520;  arc_queue.push_back(a);
      a.start_angle = 2303;  a.end_angle = 2304;   arc_queue.push_back(a);
      a.start_angle = 0;     a.end_angle = 2304;   arc_queue.push_back(a);
      a.start_angle = 46080; a.end_angle = 100;    arc_queue.push_back(a);
      a.start_angle = 65535; a.end_angle = 65535;  arc_queue.push_back(a);
      a.start_angle = 65535; a.end_angle = 19455;  arc_queue.push_back(a);
      a.start_angle = 50000; a.end_angle = 3920;   arc_queue.push_back(a);
      a.radius = 31'h7fffffff;
      a.center_x = 32'sh7fffffff; a.center_y = 32'sh80000000;
      a.center_z = 32'sh80000000;
      a.start_angle = 0;     a.end_angle = 23040;  arc_queue.push_back(a);
      a.center_x = 32'sh80000000; a.center_y = 32'sh7fffffff;
      a.center_z = 32'sh7fffffff;
      a.start_angle = 23040; a.end_angle = 0;      arc_queue.push_back(a);
      a.center_x = 0; a.center_y = 0; a.center_z = -1;
      a.start_angle = 5760;  a.end_angle = 40320;  arc_queue.push_back(a);
      a.radius = 0;
      a.start_angle = 100;   a.end_angle = 20000;  arc_queue.push_back(a);
      wait_drained();

      // random arcs, with the receiver held off while arcs keep coming
      for (int i = 0; i < 120; i++) arc_queue.push_back(rand_arc($urandom_range(0, 5) == 0));
      hold_rsp = 1'b1;
      repeat (3000) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();   // sender pause until every chord has come

      for (int i = 0; i < 70; i++) arc_queue.push_back(rand_arc($urandom_range(0, 5) == 0));
      wait_drained();
      quiet = 1'b1;
      for (int i = 0; i < 50; i++) arc_queue.push_back(rand_arc(1'b0));
      wait_drained();
      repeat (1000) @(posedge clock);

      if (fail_count == 0 && chord_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
